[hdl/xcs_pkg.sv]
// shared types and constants for the xmodem-crc sender
// used by every module of the block; depends on nothing

package xcs_pkg;

  // block geometry
  localparam int BLOCK_BYTES  = 128;
  localparam int BLOCK_ADDR_W = $clog2(BLOCK_BYTES);

  // packet byte positions
  localparam logic [7:0] POS_SOH     = 8'd0;
  localparam logic [7:0] POS_BLK     = 8'd1;
  localparam logic [7:0] POS_BLK_INV = 8'd2;
  localparam logic [7:0] POS_DATA    = 8'd3;
  localparam logic [7:0] POS_CRC_HI  = 8'(3 + BLOCK_BYTES);
  localparam logic [7:0] POS_CRC_LO  = 8'(4 + BLOCK_BYTES);

  // protocol bytes
  localparam logic [7:0] SOH_BYTE   = 8'h01;
  localparam logic [7:0] ACK_BYTE   = 8'h06;
  localparam logic [7:0] START_BYTE = 8'h43;
  localparam logic [7:0] EOT_BYTE   = 8'h04;
  localparam logic [7:0] PAD_BYTE   = 8'h1A;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // configuration
  localparam logic [7:0] RETRY_RESET = 8'd10;
  localparam logic       REG_DATA_LENGTH = 1'b0;
  localparam logic       REG_RETRY_LIMIT = 1'b1;

  // input commands
  localparam logic [1:0] CMD_PAYLOAD = 2'd0;
  localparam logic [1:0] CMD_RX_BYTE = 2'd1;
  localparam logic [1:0] CMD_TX_SLOT = 2'd2;

  // status codes
  localparam logic [1:0] ST_WAITING = 2'd0;
  localparam logic [1:0] ST_SENDING = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_FAILED  = 2'd3;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_SEND,
    PH_ACK,
    PH_EOT,
    PH_EOT_ACK,
    PH_DONE,
    PH_FAIL
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       payload_wanted;
    logic [1:0] status;
    logic [7:0] block_number;
  } out_item_t;

  typedef struct packed {
    logic [14:0] data_length;
    logic [7:0]  retry_limit;
  } cfg_t;

  // control to block buffer
  typedef struct packed {
    logic                    we;
    logic [BLOCK_ADDR_W-1:0] waddr;
    logic [7:0]              wdata;
    logic [BLOCK_ADDR_W-1:0] raddr;
  } buf_req_t;

endpackage

[hdl/xcs_block_buf.sv]
// block buffer: one write port, one registered read port with write bypass
// depends on xcs_pkg

module xcs_block_buf (
  input  logic              clk,
  input  xcs_pkg::buf_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [xcs_pkg::BLOCK_BYTES];

  // write, and read the entry the next beat will need
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.we && (req.waddr == req.raddr)) begin
      rd_data <= req.wdata;
    end else begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

[hdl/xcs_ctrl.sv]
// transfer control: phase machine, packet framing, crc and retry counting
// depends on xcs_pkg; drives the block buffer ports

module xcs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                process,
  input  xcs_pkg::in_item_t   item,
  input  xcs_pkg::cfg_t       cfg,
  input  logic [7:0]          rd_data,
  output xcs_pkg::buf_req_t   buf_req,
  output xcs_pkg::out_item_t  res
);

  xcs_pkg::phase_t phase, phase_next;
  logic [7:0]  loaded_count, loaded_count_next;
  logic [7:0]  block_index, block_index_next;
  logic [7:0]  tx_position, tx_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  attempt_count, attempt_count_next;

  logic [7:0] need_cur, need_next;
  logic [7:0] blk_num, data_idx;
  logic       attempts_used, last_block;
  logic       tx_fire;
  logic [7:0] tx_data;
  logic       buf_we;
  logic [7:0] ridx;

  // bytes the given block must hold before it can go out
  function automatic logic [7:0] need_of(input logic [7:0] bi, input logic [14:0] dl);
    logic [14:0] start;
    logic [14:0] rem;
    start = 15'(bi) << xcs_pkg::BLOCK_ADDR_W;
    rem   = dl - start;
    if (dl <= start) begin
      need_of = 8'd0;
    end else if (rem < 15'(xcs_pkg::BLOCK_BYTES)) begin
      need_of = rem[7:0];
    end else begin
      need_of = 8'(xcs_pkg::BLOCK_BYTES);
    end
  endfunction

  // crc-16/xmodem, one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ xcs_pkg::CRC_POLY) : (c << 1);
    end
    crc_byte = c;
  endfunction

  assign need_cur      = need_of(block_index, cfg.data_length);
  assign blk_num       = block_index + 8'd1;
  assign data_idx      = tx_position - xcs_pkg::POS_DATA;
  assign attempts_used = (attempt_count >= cfg.retry_limit);
  assign last_block    = (15'(block_index) >= (cfg.data_length >> xcs_pkg::BLOCK_ADDR_W));

  // next state
  always_comb begin
    phase_next         = phase;
    loaded_count_next  = loaded_count;
    block_index_next   = block_index;
    tx_position_next   = tx_position;
    running_crc_next   = running_crc;
    attempt_count_next = attempt_count;
    tx_fire            = 1'b0;
    tx_data            = 8'd0;
    buf_we             = 1'b0;
    if (process) begin
      case (item.command)
        xcs_pkg::CMD_PAYLOAD: begin
          if ((phase == xcs_pkg::PH_WAIT || phase == xcs_pkg::PH_SEND) &&
              loaded_count < need_cur) begin
            buf_we            = 1'b1;
            loaded_count_next = loaded_count + 8'd1;
          end
        end
        xcs_pkg::CMD_RX_BYTE: begin
          case (phase)
            xcs_pkg::PH_WAIT: begin
              if (item.byte_value == xcs_pkg::START_BYTE) begin
                phase_next         = xcs_pkg::PH_SEND;
                tx_position_next   = 8'd0;
                running_crc_next   = 16'd0;
                attempt_count_next = 8'd0;
              end
            end
            xcs_pkg::PH_ACK: begin
              if (item.byte_value == xcs_pkg::ACK_BYTE) begin
                if (last_block) begin
                  phase_next         = xcs_pkg::PH_EOT;
                  attempt_count_next = 8'd0;
                end else begin
                  phase_next         = xcs_pkg::PH_SEND;
                  block_index_next   = block_index + 8'd1;
                  loaded_count_next  = 8'd0;
                  tx_position_next   = 8'd0;
                  running_crc_next   = 16'd0;
                  attempt_count_next = 8'd0;
                end
              end else if (attempts_used) begin
                phase_next = xcs_pkg::PH_FAIL;
              end else begin
                phase_next       = xcs_pkg::PH_SEND;
                tx_position_next = 8'd0;
                running_crc_next = 16'd0;
              end
            end
            xcs_pkg::PH_EOT_ACK: begin
              if (item.byte_value == xcs_pkg::ACK_BYTE) begin
                phase_next = xcs_pkg::PH_DONE;
              end else if (attempts_used) begin
                phase_next = xcs_pkg::PH_FAIL;
              end else begin
                phase_next = xcs_pkg::PH_EOT;
              end
            end
            default: ;
          endcase
        end
        xcs_pkg::CMD_TX_SLOT: begin
          if (phase == xcs_pkg::PH_SEND && loaded_count >= need_cur) begin
            if (tx_position == xcs_pkg::POS_SOH && attempts_used) begin
              phase_next = xcs_pkg::PH_FAIL;
            end else begin
              tx_fire = 1'b1;
              if (tx_position == xcs_pkg::POS_SOH) begin
                attempt_count_next = attempt_count + 8'd1;
                tx_data            = xcs_pkg::SOH_BYTE;
              end else if (tx_position == xcs_pkg::POS_BLK) begin
                tx_data = blk_num;
              end else if (tx_position == xcs_pkg::POS_BLK_INV) begin
                tx_data = ~blk_num;
              end else if (tx_position < xcs_pkg::POS_CRC_HI) begin
                tx_data          = (data_idx < need_cur) ? rd_data : xcs_pkg::PAD_BYTE;
                running_crc_next = crc_byte(running_crc, tx_data);
              end else if (tx_position == xcs_pkg::POS_CRC_HI) begin
                tx_data = running_crc[15:8];
              end else begin
                tx_data = running_crc[7:0];
              end
              if (tx_position >= xcs_pkg::POS_CRC_LO) begin
                tx_position_next = 8'd0;
                phase_next       = xcs_pkg::PH_ACK;
              end else begin
                tx_position_next = tx_position + 8'd1;
              end
            end
          end else if (phase == xcs_pkg::PH_EOT) begin
            if (attempts_used) begin
              phase_next = xcs_pkg::PH_FAIL;
            end else begin
              attempt_count_next = attempt_count + 8'd1;
              tx_fire            = 1'b1;
              tx_data            = xcs_pkg::EOT_BYTE;
              phase_next         = xcs_pkg::PH_EOT_ACK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // buffer addressing: prefetch the data byte for the next position
  assign ridx    = tx_position_next - xcs_pkg::POS_DATA;
  assign buf_req = xcs_pkg::buf_req_t'{
    we:    buf_we,
    waddr: loaded_count[xcs_pkg::BLOCK_ADDR_W-1:0],
    wdata: item.byte_value,
    raddr: ridx[xcs_pkg::BLOCK_ADDR_W-1:0]
  };

  assign need_next = need_of(block_index_next, cfg.data_length);

  // result fields, taken from the state after this beat
  always_comb begin
    res.tx_valid       = tx_fire;
    res.tx_byte        = tx_data;
    res.payload_wanted = (phase_next == xcs_pkg::PH_WAIT || phase_next == xcs_pkg::PH_SEND) &&
                         (loaded_count_next < need_next);
    res.block_number   = block_index_next + 8'd1;
    case (phase_next)
      xcs_pkg::PH_WAIT: res.status = xcs_pkg::ST_WAITING;
      xcs_pkg::PH_DONE: res.status = xcs_pkg::ST_DONE;
      xcs_pkg::PH_FAIL: res.status = xcs_pkg::ST_FAILED;
      default:          res.status = xcs_pkg::ST_SENDING;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= xcs_pkg::PH_WAIT;
      loaded_count  <= 8'd0;
      block_index   <= 8'd0;
      tx_position   <= 8'd0;
      running_crc   <= 16'd0;
      attempt_count <= 8'd0;
    end else begin
      phase         <= phase_next;
      loaded_count  <= loaded_count_next;
      block_index   <= block_index_next;
      tx_position   <= tx_position_next;
      running_crc   <= running_crc_next;
      attempt_count <= attempt_count_next;
    end
  end

endmodule

[hdl/xmodem_crc_sender_unit.sv]
// top level of the xmodem-crc sender: input register, control, block
// buffer and result register; depends on xcs_pkg, xcs_ctrl, xcs_block_buf

// Usage
//   in channel (in_valid/in_ready/in_data): one beat per event: a payload
//   byte, a byte received from the far end, or a free transmit slot.
//   out channel (out_valid/out_ready/out_data): exactly one result beat per
//   input beat, carrying the byte to transmit (if any), payload_wanted,
//   status and the current block number.
//   cfg port: cfg_we writes cfg_wdata to register cfg_index (0 data_length,
//   1 retry_limit) in the same cycle; write only while the block is idle.
// Timing
//   an input beat goes through the input register, then one pass through
//   framing, crc and state update into the result register; throughput is
//   one beat per cycle while out_ready does not hold the result, set by the
//   byte-wide crc update and the block buffer's one registered read port.
// Reset
//   rst (synchronous) empties both registers, returns to waiting for the
//   start byte at block 1, data_length 0 and retry_limit 10.
// Back-pressure
//   while out_ready is low the result stays held, one more beat may wait in
//   the input register, and in_ready falls once both are full.

module xmodem_crc_sender_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  xcs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output xcs_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_wdata
);

  xcs_pkg::cfg_t      cfg;
  xcs_pkg::in_item_t  in_q;
  logic               in_q_valid;
  logic               advance;
  logic               process;
  xcs_pkg::buf_req_t  buf_req;
  logic [7:0]         rd_data;
  xcs_pkg::out_item_t res;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_q_valid || advance;
  assign process  = in_q_valid && advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_length <= 15'd0;
      cfg.retry_limit <= xcs_pkg::RETRY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        xcs_pkg::REG_DATA_LENGTH: cfg.data_length <= cfg_wdata;
        xcs_pkg::REG_RETRY_LIMIT: cfg.retry_limit <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  xcs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .process (process),
    .item    (in_q),
    .cfg     (cfg),
    .rd_data (rd_data),
    .buf_req (buf_req),
    .res     (res)
  );

  xcs_block_buf u_buf (
    .clk     (clk),
    .req     (buf_req),
    .rd_data (rd_data)
  );

  // result beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      out_data <= res;
    end
  end

endmodule
